// File: design/fup_pkg.sv
package fup_pkg;

   // result codes
   typedef enum logic [3:0] {
      EV_READY_SIZE   = 4'd0,
      EV_ERASE_REQ    = 4'd1,
      EV_READY_DATA   = 4'd2,
      EV_PROGRAM_WORD = 4'd3,
      EV_CHUNK_ACK    = 4'd4,
      EV_READY_END    = 4'd5,
      EV_COMPLETE     = 4'd6,
      EV_BAD_HEADER   = 4'd7,
      EV_BAD_SIZE     = 4'd8,
      EV_ERASE_ERR    = 4'd9,
      EV_WRITE_ERR    = 4'd10,
      EV_BAD_END      = 4'd11,
      EV_READY_HEADER = 4'd12
   } event_type;

   typedef enum logic [2:0] {
      PH_HDR1 = 3'd0,
      PH_HDR2 = 3'd1,
      PH_SIZE = 3'd2,
      PH_DATA = 3'd3,
      PH_END  = 3'd4
   } phase_type;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_IMAGE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE_ADDR = 2'd1;

   localparam logic [23:0] MAX_IMAGE_RESET = 24'd475136;
   localparam logic [31:0] BASE_ADDR_RESET = 32'h0800_C000;
   localparam logic [7:0]  HDR1_BYTE = 8'hAA;
   localparam logic [7:0]  HDR2_BYTE = 8'h55;
   localparam logic [7:0]  END_BYTE  = 8'h5A;

   localparam int QUEUE_DEPTH = 2;

   // results caused by one byte, up to three
   typedef struct packed {
      logic [1:0]            cnt;
      event_type [2:0]       ev;
      logic [31:0]           addr;
      logic [31:0]           data;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: design/fup_front.sv
module fup_front
   import fup_pkg::*;
#(
   parameter int CHUNK_BYTES = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_rx_byte,
   input  logic                       req_flash_fail,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_wdata,
   input  queue_status_type           q_status,
   output logic                       push,
   output desc_type                   push_desc
);

   localparam int OFF_W = $clog2(CHUNK_BYTES);
   localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(CHUNK_BYTES - 1);

   phase_type        phase_ff, phase_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [23:0]      sa_ff, sa_in;
   logic [23:0]      isz_ff, isz_in;
   logic [23:0]      bw_ff, bw_in;
   logic [23:0]      wa_ff, wa_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [23:0]      max_ff;
   logic [31:0]      base_ff;

   logic        accept;
   desc_type    d;
   logic [1:0]  fill;
   logic [23:0] after;
   logic        chunk_end, image_end, word_end;
   logic [31:0] word;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && (d.cnt != 2'd0);
   assign push_desc = d;

   assign fill      = off_ff[1:0];
   assign after     = bw_ff + 24'd1;
   assign chunk_end = (off_ff == OFF_LAST);
   assign image_end = (after >= isz_ff);
   assign word_end  = (fill == 2'd3) || chunk_end || image_end;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      sa_in    = sa_ff;
      isz_in   = isz_ff;
      bw_in    = bw_ff;
      wa_in    = wa_ff;
      off_in   = off_ff;
      word     = {8'hFF, wa_ff};
      word[{fill, 3'b000} +: 8] = req_rx_byte;
      d.cnt    = 2'd0;
      d.ev[0]  = EV_READY_HEADER;
      d.ev[1]  = EV_READY_HEADER;
      d.ev[2]  = EV_READY_HEADER;
      d.addr   = 32'd0;
      d.data   = 32'd0;
      case (phase_ff)
         PH_HDR1: begin
            if (req_rx_byte == HDR1_BYTE) begin
               phase_in = PH_HDR2;
            end
         end
         PH_HDR2: begin
            if (req_rx_byte == HDR2_BYTE) begin
               d.cnt    = 2'd1;
               d.ev[0]  = EV_READY_SIZE;
               cnt_in   = 2'd0;
               sa_in    = 24'd0;
               phase_in = PH_SIZE;
            end else begin
               d.cnt   = 2'd2;
               d.ev[0] = EV_BAD_HEADER;
               phase_in = PH_HDR1;
            end
         end
         PH_SIZE: begin
            if (cnt_ff != 2'd3) begin
               sa_in[{cnt_ff, 3'b000} +: 8] = sa_ff[{cnt_ff, 3'b000} +: 8] | req_rx_byte;
               cnt_in = cnt_ff + 2'd1;
            end else if (req_rx_byte != 8'd0 || sa_ff == 24'd0 || sa_ff > max_ff) begin
               d.cnt    = 2'd2;
               d.ev[0]  = EV_BAD_SIZE;
               phase_in = PH_HDR1;
            end else if (req_flash_fail) begin
               d.cnt    = 2'd3;
               d.ev[0]  = EV_ERASE_REQ;
               d.ev[1]  = EV_ERASE_ERR;
               phase_in = PH_HDR1;
            end else begin
               d.cnt    = 2'd2;
               d.ev[0]  = EV_ERASE_REQ;
               d.ev[1]  = EV_READY_DATA;
               isz_in   = sa_ff;
               cnt_in   = 2'd0;
               bw_in    = 24'd0;
               off_in   = '0;
               wa_in    = 24'hFF_FFFF;
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            bw_in  = after;
            off_in = chunk_end ? '0 : off_ff + OFF_W'(1);
            if (!word_end) begin
               wa_in[{fill, 3'b000} +: 8] = req_rx_byte;
            end else begin
               d.ev[0] = EV_PROGRAM_WORD;
               d.addr  = base_ff + {8'd0, bw_ff - {22'd0, fill}};
               d.data  = word;
               wa_in   = 24'hFF_FFFF;
               if (req_flash_fail) begin
                  d.cnt    = 2'd3;
                  d.ev[1]  = EV_WRITE_ERR;
                  phase_in = PH_HDR1;
               end else if (image_end) begin
                  d.cnt    = 2'd3;
                  d.ev[1]  = EV_CHUNK_ACK;
                  d.ev[2]  = EV_READY_END;
                  phase_in = PH_END;
               end else if (chunk_end) begin
                  d.cnt   = 2'd2;
                  d.ev[1] = EV_CHUNK_ACK;
               end else begin
                  d.cnt = 2'd1;
               end
            end
         end
         PH_END: begin
            d.cnt    = 2'd2;
            d.ev[0]  = (req_rx_byte == END_BYTE) ? EV_COMPLETE : EV_BAD_END;
            phase_in = PH_HDR1;
         end
         default: begin
            d.cnt    = 2'd1;
            phase_in = PH_HDR1;
         end
      endcase
      // every error and frame end drops back to header hunting
      if (phase_ff != PH_HDR1 && phase_in == PH_HDR1) begin
         cnt_in = 2'd0;
         sa_in  = 24'd0;
         isz_in = 24'd0;
         bw_in  = 24'd0;
         off_in = '0;
         wa_in  = 24'hFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR1;
         cnt_ff   <= 2'd0;
         sa_ff    <= 24'd0;
         isz_ff   <= 24'd0;
         bw_ff    <= 24'd0;
         wa_ff    <= 24'hFF_FFFF;
         off_ff   <= '0;
         max_ff   <= MAX_IMAGE_RESET;
         base_ff  <= BASE_ADDR_RESET;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
            sa_ff    <= sa_in;
            isz_ff   <= isz_in;
            bw_ff    <= bw_in;
            wa_ff    <= wa_in;
            off_ff   <= off_in;
         end
         if (csr_valid && csr_index == CSR_MAX_IMAGE) begin
            max_ff <= csr_wdata[23:0];
         end
         if (csr_valid && csr_index == CSR_BASE_ADDR) begin
            base_ff <= csr_wdata;
         end
      end
   end

endmodule

// File: design/fup_queue.sv
module fup_queue
   import fup_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  desc_type         push_desc,
   input  logic             pop,
   output desc_type         pop_desc,
   output queue_status_type q_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   desc_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign q_status.full  = (cnt_ff == CNT_FULL);
   assign q_status.empty = (cnt_ff == '0);
   assign pop_desc       = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_desc;
      end
   end

endmodule

// File: design/fup_back.sv
module fup_back
   import fup_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  desc_type         pop_desc,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [3:0]       rsp_event_res,
   output logic [31:0]      rsp_flash_address,
   output logic [31:0]      rsp_program_data,
   output logic             rsp_last
);

   desc_type   cur_ff;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   event_type  ev;

   assign ev                = cur_ff.ev[idx_ff];
   assign rsp_valid         = busy_ff;
   assign rsp_event_res     = ev;
   assign rsp_last          = (idx_ff == cur_ff.cnt - 2'd1);
   assign rsp_flash_address = (ev == EV_PROGRAM_WORD) ? cur_ff.addr : 32'd0;
   assign rsp_program_data  = (ev == EV_PROGRAM_WORD) ? cur_ff.data : 32'd0;
   assign pop = !q_status.empty && (!busy_ff || (rsp_ready && rsp_last));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (busy_ff && rsp_ready) begin
         if (rsp_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= pop_desc;
      end
   end

endmodule

// File: design/firmware_upload_frame_parser.sv
// channel | direction | ports                                         | moves
// req     | in        | req_valid/ready, rx_byte, flash_fail          | one received byte
// rsp     | out       | rsp_valid/ready, event_res, flash_address,    | one result word
//         |           | program_data, last                            |
// csr     | in        | csr_valid/ready, csr_index, csr_wdata         | one register write
//
// a byte is parsed in the cycle it is accepted; its results (zero to three) go
// into a two-entry queue as one entry, so req_ready only drops while the queue is full
// the result side drains one word per cycle while rsp_ready is high, so a byte puts zero to three
// words on rsp, set by the count of results that it causes
// reset (synchronous) restores both registers and sends the parser to header hunting
// rsp stalls back up into the queue and then into req; csr is always ready
module firmware_upload_frame_parser
   import fup_pkg::*;
#(
   parameter int CHUNK_BYTES = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_rx_byte,
   input  logic                       req_flash_fail,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [3:0]                 rsp_event_res,
   output logic [31:0]                rsp_flash_address,
   output logic [31:0]                rsp_program_data,
   output logic                       rsp_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_wdata
);

   queue_status_type q_status;
   logic             push, pop;
   desc_type         push_desc, pop_desc;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;

   // front: header, size and data parsing, word packing
   fup_front #(
      .CHUNK_BYTES(CHUNK_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .req_flash_fail(req_flash_fail),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_status      (q_status),
      .push          (push),
      .push_desc     (push_desc)
   );

   // queue of per-byte result groups
   fup_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_desc(push_desc),
      .pop      (pop),
      .pop_desc (pop_desc),
      .q_status (q_status)
   );

   // back: serializes each group onto rsp
   fup_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .pop_desc         (pop_desc),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_flash_address(rsp_flash_address),
      .rsp_program_data (rsp_program_data),
      .rsp_last         (rsp_last)
   );

   // ready_header always closes a byte's results
   a_hdr_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_READY_HEADER) |-> rsp_last)
      else $error("ready_header not marked last");

   // a group is not cut short: after a non-last word another follows
   a_group_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("result group broken off");

   // address and data are zero outside program words
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res != EV_PROGRAM_WORD)
         |-> (rsp_flash_address == 32'd0 && rsp_program_data == 32'd0))
      else $error("payload on non-program result");

   // no push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("result queue overflow");

endmodule

// File: tb/sv/tb_firmware_upload_frame_parser.sv
`timescale 1ns / 100ps

// upload frame parser bench: frames of random content and shape are fed one byte
// per word; a cycle-free model of the parser predicts the result words, and a
// monitor checks every accepted result word against the oldest prediction
module tb_firmware_upload_frame_parser
   import fup_pkg::*;
#(
   parameter int CHUNK_BYTES = 512
);

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASE_BYTES   = 60;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_SHOWN     = 10;

   // shapes of generated frames
   typedef enum {
      FRAME_GOOD,
      FRAME_BAD_HEADER,
      FRAME_BAD_SIZE,
      FRAME_ERASE_FAIL,
      FRAME_WRITE_FAIL,
      FRAME_BAD_END
   } frame_kind_type;

   typedef struct packed {
      logic [7:0] value;
      logic       fail;
   } upload_byte_type;

   typedef struct packed {
      event_type   ev;
      logic [31:0] addr;
      logic [31:0] data;
      logic        last;
   } parse_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_rx_byte = '0;
   logic                       req_flash_fail = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [3:0]                 rsp_event_res;
   logic [31:0]                rsp_flash_address;
   logic [31:0]                rsp_program_data;
   logic                       rsp_last;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0]                csr_wdata = '0;

   // bytes waiting to be driven, and result words waiting to be seen
   upload_byte_type  pending_bytes[$];
   parse_result_type expected_results[$];

   // register copies, kept in step with accepted csr writes
   logic [23:0] max_image_cfg;
   logic [31:0] base_addr_cfg;

   // parser state as the model sees it
   phase_type   parser_phase;
   logic [1:0]  size_count;
   logic [23:0] size_acc;
   logic [23:0] image_len;
   logic [23:0] bytes_done;
   logic [23:0] word_acc;

   // results of the byte being parsed, before they join the expected queue
   parse_result_type step_results[0:2];
   int               step_count;

   int              items_queued = 0;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              send_gap = 0;
   int              send_calm = 0;
   int              recv_stall = 0;
   int              recv_calm = 0;
   upload_byte_type launch;

   firmware_upload_frame_parser #(
      .CHUNK_BYTES(CHUNK_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .req_flash_fail   (req_flash_fail),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_flash_address(rsp_flash_address),
      .rsp_program_data (rsp_program_data),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   // back to hunting for the header, everything cleared
   function automatic void restart_parser();
      parser_phase = PH_HDR1;
      size_count   = '0;
      size_acc     = '0;
      image_len    = '0;
      bytes_done   = '0;
      word_acc     = '1;
   endfunction

   function automatic void note_event(event_type ev, logic [31:0] addr, logic [31:0] data);
      step_results[step_count] = '{ev: ev, addr: addr, data: data, last: 1'b0};
      step_count++;
   endfunction

   // advance the model by one accepted byte and queue the result words it causes
   function automatic void parse_byte(logic [7:0] b, logic fail);
      int unsigned in_chunk;
      int unsigned fill;
      logic [31:0] word_start;
      logic [23:0] after;
      logic [31:0] word;
      logic        chunk_end;
      logic        image_end;

      step_count = 0;
      case (parser_phase)
         PH_HDR1: begin
            // anything but the first header byte is dropped silently
            if (b == HDR1_BYTE) parser_phase = PH_HDR2;
         end
         PH_HDR2: begin
            if (b == HDR2_BYTE) begin
               note_event(EV_READY_SIZE, '0, '0);
               size_count   = '0;
               size_acc     = '0;
               parser_phase = PH_SIZE;
            end else begin
               // no second look at this byte as a first header byte
               note_event(EV_BAD_HEADER, '0, '0);
               note_event(EV_READY_HEADER, '0, '0);
               restart_parser();
            end
         end
         PH_SIZE: begin
            if (size_count < 2'd3) begin
               size_acc[8*size_count +: 8] = b;
               size_count++;
            end else if (b != 8'd0 || size_acc == '0 || size_acc > max_image_cfg) begin
               // top size byte set means beyond any 24-bit limit
               note_event(EV_BAD_SIZE, '0, '0);
               note_event(EV_READY_HEADER, '0, '0);
               restart_parser();
            end else begin
               note_event(EV_ERASE_REQ, '0, '0);
               if (fail) begin
                  note_event(EV_ERASE_ERR, '0, '0);
                  note_event(EV_READY_HEADER, '0, '0);
                  restart_parser();
               end else begin
                  note_event(EV_READY_DATA, '0, '0);
                  image_len    = size_acc;
                  size_count   = '0;
                  bytes_done   = '0;
                  word_acc     = '1;
                  parser_phase = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            // words restart at every chunk start, so offsets are chunk relative
            in_chunk   = bytes_done % CHUNK_BYTES;
            fill       = in_chunk & 3;
            word_start = {8'd0, bytes_done} - fill;
            after      = bytes_done + 24'd1;
            chunk_end  = (in_chunk + 1) == CHUNK_BYTES;
            image_end  = after >= image_len;
            bytes_done = after;
            if (fill != 3 && !chunk_end && !image_end) begin
               word_acc[8*fill +: 8] = b;
            end else begin
               // short words keep 0xff in the bytes never filled
               word = {8'hFF, word_acc};
               word[8*fill +: 8] = b;
               note_event(EV_PROGRAM_WORD, base_addr_cfg + word_start, word);
               word_acc = '1;
               if (fail) begin
                  note_event(EV_WRITE_ERR, '0, '0);
                  note_event(EV_READY_HEADER, '0, '0);
                  restart_parser();
               end else begin
                  if (chunk_end || image_end) note_event(EV_CHUNK_ACK, '0, '0);
                  if (image_end) begin
                     note_event(EV_READY_END, '0, '0);
                     parser_phase = PH_END;
                  end
               end
            end
         end
         PH_END: begin
            note_event(b == END_BYTE ? EV_COMPLETE : EV_BAD_END, '0, '0);
            note_event(EV_READY_HEADER, '0, '0);
            restart_parser();
         end
         default: begin
            note_event(EV_READY_HEADER, '0, '0);
            restart_parser();
         end
      endcase

      for (int i = 0; i < step_count; i++) begin
         step_results[i].last = (i == step_count - 1);
         expected_results.push_back(step_results[i]);
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   // mostly short gaps, a few long ones, and now and then a calm stretch
   function automatic int pick_gap(inout int calm);
      int r;

      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic void push_byte(logic [7:0] value, logic fail);
      pending_bytes.push_back({value, fail});
      items_queued++;
   endfunction

   function automatic frame_kind_type pick_kind();
      int r;

      r = $urandom_range(0, 99);
      if (r < 58) return FRAME_GOOD;
      if (r < 66) return FRAME_BAD_HEADER;
      if (r < 74) return FRAME_BAD_SIZE;
      if (r < 82) return FRAME_ERASE_FAIL;
      if (r < 92) return FRAME_WRITE_FAIL;
      return FRAME_BAD_END;
   endfunction

   // queue one frame; it stops right after the byte where it goes wrong
   function automatic void queue_frame(frame_kind_type kind, int forced_size);
      int          size;
      int          lim;
      int          fail_at;
      logic [7:0]  top;
      logic [7:0]  b;
      logic        word_end;
      int          in_chunk;

      // line noise ahead of the header, never a first header byte
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom);
            if (b == HDR1_BYTE) b = 8'h3C;
            pending_bytes.push_back({b, 1'($urandom_range(0, 1))});
         end
      end

      push_byte(HDR1_BYTE, 1'($urandom_range(0, 1)));
      if (kind == FRAME_BAD_HEADER) begin
         b = 8'($urandom);
         if ($urandom_range(0, 2) == 0) b = HDR1_BYTE;
         else if (b == HDR2_BYTE) b = 8'h54;
         push_byte(b, 1'($urandom_range(0, 1)));
         return;
      end
      push_byte(HDR2_BYTE, 1'($urandom_range(0, 1)));

      lim = (max_image_cfg <= 80) ? max_image_cfg : 40;
      top = 8'd0;
      if (kind == FRAME_BAD_SIZE) begin
         case ($urandom_range(0, 2))
            0: size = 0;
            1: begin
               if (max_image_cfg == 24'hFF_FFFF) begin
                  size = $urandom_range(1, lim);
                  top  = 8'($urandom_range(1, 255));
               end else begin
                  size = max_image_cfg + $urandom_range(1, 3);
               end
            end
            default: begin
               size = $urandom_range(1, lim);
               top  = 8'($urandom_range(1, 255));
            end
         endcase
      end else if (forced_size > 0) begin
         size = forced_size;
      end else if ($urandom_range(0, 9) == 0) begin
         size = lim;
      end else begin
         size = $urandom_range(1, lim);
      end

      push_byte(size[7:0], 1'($urandom_range(0, 1)));
      push_byte(size[15:8], 1'($urandom_range(0, 1)));
      push_byte(size[23:16], 1'($urandom_range(0, 1)));
      if (kind == FRAME_BAD_SIZE) begin
         push_byte(top, 1'($urandom_range(0, 1)));
         return;
      end
      push_byte(top, kind == FRAME_ERASE_FAIL);
      if (kind == FRAME_ERASE_FAIL) return;

      // fail only on a byte that closes a word; elsewhere the flag is don't care
      fail_at = (kind == FRAME_WRITE_FAIL) ? $urandom_range(0, size - 1) : size;
      for (int i = 0; i < size; i++) begin
         in_chunk = i % CHUNK_BYTES;
         word_end = (in_chunk % 4 == 3) || (in_chunk == CHUNK_BYTES - 1) || (i == size - 1);
         b = 8'($urandom);
         if (word_end) begin
            push_byte(b, i >= fail_at);
            if (i >= fail_at) return;
         end else begin
            push_byte(b, 1'($urandom_range(0, 1)));
         end
      end

      b = END_BYTE;
      if (kind == FRAME_BAD_END) begin
         b = 8'($urandom);
         if (b == END_BYTE) b = 8'h5B;
      end
      push_byte(b, 1'($urandom_range(0, 1)));
   endfunction

   // extremes first: stray bytes, a repeated first header byte, a zero size,
   // then a short image whose last word is padded
   function automatic void queue_directed();
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(HDR1_BYTE, 1'b0);
      push_byte(HDR1_BYTE, 1'b1);
      push_byte(HDR2_BYTE, 1'b0);
      push_byte(HDR1_BYTE, 1'b0);
      push_byte(HDR2_BYTE, 1'b0);
      repeat (4) push_byte(8'h00, 1'b0);
      push_byte(HDR1_BYTE, 1'b0);
      push_byte(HDR2_BYTE, 1'b0);
      push_byte(8'h05, 1'b0);
      repeat (3) push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h80, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(END_BYTE, 1'b0);
      // a stray end byte while hunting for the header
      push_byte(END_BYTE, 1'b0);
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MAX_IMAGE) max_image_cfg = value[23:0];
      else if (idx == CSR_BASE_ADDR) base_addr_cfg = value;
      csr_valid <= 1'b0;
   endtask

   // nothing queued, nothing in flight, nothing outstanding, then a short settle;
   // checked mid-cycle so every edge's updates have landed
   task automatic wait_idle(input int settle);
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      int phase_start;

      max_image_cfg = MAX_IMAGE_RESET;
      base_addr_cfg = BASE_ADDR_RESET;
      restart_parser();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // four register settings; the first is the reset one
      for (int setting = 0; setting < 4; setting++) begin
         case (setting)
            1: begin
               // smallest limit, base at the very top of the address space
               write_csr(CSR_MAX_IMAGE, {8'($urandom), 24'd1});
               write_csr(CSR_BASE_ADDR, 32'hFFFF_FFFF);
            end
            2: begin
               write_csr(CSR_MAX_IMAGE, {8'($urandom), 24'hFF_FFFF});
               write_csr(CSR_BASE_ADDR, 32'h0000_0000);
            end
            3: begin
               write_csr(CSR_MAX_IMAGE, {8'($urandom), 24'($urandom_range(4, 80))});
               write_csr(CSR_BASE_ADDR, $urandom);
            end
            default: ;
         endcase

         phase_start = items_queued;
         if (setting == 0) begin
            queue_directed();
            // crosses one chunk boundary
            queue_frame(FRAME_GOOD, CHUNK_BYTES + $urandom_range(1, 8));
         end
         while (items_queued - phase_start < PHASE_BYTES)
            queue_frame(pick_kind(), 0);
         wait_idle(SETTLE_CYCLES);
      end

      wait_idle(3 * SETTLE_CYCLES);
      if (mismatch_count == 0) begin
         $display("tb_firmware_upload_frame_parser: done, clean");
      end else begin
         $display("tb_firmware_upload_frame_parser: done, errors");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver

   // one byte per input word; the model is stepped on each accepted word
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) parse_byte(req_rx_byte, req_flash_fail);
         // a word not yet taken stays put
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               launch          = pending_bytes.pop_front();
               req_rx_byte    <= launch.value;
               req_flash_fail <= launch.fail;
               req_valid      <= 1'b1;
               send_gap       <= pick_gap(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   function automatic void check_result();
      parse_result_type want;

      if (expected_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_SHOWN)
            $display("unexpected result word: event %0d addr %h data %h last %b",
                     rsp_event_res, rsp_flash_address, rsp_program_data, rsp_last);
         return;
      end
      want = expected_results.pop_front();
      if (rsp_event_res !== want.ev || rsp_flash_address !== want.addr ||
          rsp_program_data !== want.data || rsp_last !== want.last) begin
         mismatch_count++;
         if (mismatch_count <= MAX_SHOWN)
            $display("result mismatch: event %0d/%0d addr %h/%h data %h/%h last %b/%b",
                     want.ev, rsp_event_res, want.addr, rsp_flash_address,
                     want.data, rsp_program_data, want.last, rsp_last);
      end
   endfunction

   // result words are checked in order; ready drops for random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < 20) recv_stall <= pick_gap(recv_calm);
         end
      end
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_firmware_upload_frame_parser: done, errors");
         $finish;
      end
   end

endmodule
